/* sv/cbsu_pkg.sv */
// ----------------------------------------------------------------------------
// cbsu_pkg: shared types and constants
// Opcode codes, condition codes and the item and result structs of the
// branch and system unit.
// ----------------------------------------------------------------------------
package cbsu_pkg;

  localparam logic [7:0] OP_JMP     = 8'hC3;
  localparam logic [7:0] OP_JMP_ALT = 8'hCB;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_RET_ALT = 8'hD9;
  localparam logic [7:0] OP_HLT     = 8'h76;
  localparam logic [7:0] OP_EI      = 8'hFB;
  localparam logic [7:0] OP_DI      = 8'hF3;
  localparam logic [7:0] OP_OUT     = 8'hD3;
  localparam logic [7:0] OP_IN      = 8'hDB;

  // Opcode group masks and patterns
  localparam logic [7:0] MASK_CCC   = 8'hC7;
  localparam logic [7:0] MASK_CALL  = 8'hCF;
  localparam logic [7:0] PAT_JCC    = 8'hC2;
  localparam logic [7:0] PAT_CALL   = 8'hCD;
  localparam logic [7:0] PAT_CCC    = 8'hC4;
  localparam logic [7:0] PAT_RCC    = 8'hC0;
  localparam logic [7:0] PAT_RST    = 8'hC7;
  localparam logic [7:0] RST_MASK   = 8'h38;

  localparam logic [2:0]  TAKEN_EXTRA = 3'd6;
  localparam logic [15:0] STACK_STEP  = 16'd2;

  // Flag selected by bits 5:4 of the opcode
  typedef enum logic [1:0] {
    FLAG_ZERO   = 2'd0,
    FLAG_CARRY  = 2'd1,
    FLAG_PARITY = 2'd2,
    FLAG_SIGN   = 2'd3
  } flag_sel_e;

  typedef struct packed {
    logic [7:0]  func;
    logic [15:0] imm_word;
    logic [15:0] fall_through_pc;
    logic [15:0] stack_pointer;
    logic [15:0] stack_top_word;
    logic [7:0]  acc;
    logic [7:0]  port_data_in;
    logic        zero_flag;
    logic        carry_flag;
    logic        parity_flag;
    logic        sign_flag;
  } item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic        push_valid;
    logic [15:0] push_word;
    logic        port_write;
    logic        port_read;
    logic [7:0]  port_number;
    logic [7:0]  port_data_out;
    logic [7:0]  new_acc;
    logic [2:0]  extra_cycles;
    logic        halted_out;
    logic        int_enabled_out;
  } result_t;

  typedef struct packed {
    logic halted;
    logic int_enable;
  } sys_state_t;

endpackage

/* sv/cbsu_exec.sv */
// ----------------------------------------------------------------------------
// cbsu_exec: instruction execute logic
// Decodes one control or system opcode and forms its result and the next
// halt and interrupt-enable state.
// ----------------------------------------------------------------------------
module cbsu_exec
  import cbsu_pkg::*;
(
  input  item_t      item_i,
  input  sys_state_t state_i,
  output result_t    result_o,
  output sys_state_t state_o
);

  logic [2:0] ccc;
  logic       flag;
  logic       cond;
  logic       do_call;
  logic       do_ret;
  logic [15:0] target;

  assign ccc = item_i.func[5:3];

  always_comb begin
    case (flag_sel_e'(ccc[2:1]))
      FLAG_ZERO:   flag = item_i.zero_flag;
      FLAG_CARRY:  flag = item_i.carry_flag;
      FLAG_PARITY: flag = item_i.parity_flag;
      FLAG_SIGN:   flag = item_i.sign_flag;
      default:     flag = item_i.sign_flag;
    endcase
  end

  // Odd codes test for a set flag, even codes for a clear one
  assign cond = ccc[0] ? flag : ~flag;

  always_comb begin
    result_o               = '0;
    result_o.next_pc       = item_i.fall_through_pc;
    result_o.next_sp       = item_i.stack_pointer;
    result_o.push_word     = item_i.fall_through_pc;
    result_o.new_acc       = item_i.acc;
    state_o                = state_i;
    do_call                = 1'b0;
    do_ret                 = 1'b0;
    target                 = item_i.imm_word;

    if (item_i.func == OP_JMP || item_i.func == OP_JMP_ALT) begin
      result_o.next_pc = item_i.imm_word;
    end else if ((item_i.func & MASK_CCC) == PAT_JCC) begin
      if (cond) result_o.next_pc = item_i.imm_word;
    end else if ((item_i.func & MASK_CALL) == PAT_CALL) begin
      do_call = 1'b1;
    end else if ((item_i.func & MASK_CCC) == PAT_CCC) begin
      if (cond) begin
        do_call               = 1'b1;
        result_o.extra_cycles = TAKEN_EXTRA;
      end
    end else if (item_i.func == OP_RET || item_i.func == OP_RET_ALT) begin
      do_ret = 1'b1;
    end else if ((item_i.func & MASK_CCC) == PAT_RCC) begin
      if (cond) begin
        do_ret                = 1'b1;
        result_o.extra_cycles = TAKEN_EXTRA;
      end
    end else if ((item_i.func & MASK_CCC) == PAT_RST) begin
      do_call = 1'b1;
      target  = {8'h00, item_i.func & RST_MASK};
    end else if (item_i.func == OP_HLT) begin
      state_o.halted = 1'b1;
    end else if (item_i.func == OP_EI) begin
      state_o.int_enable = 1'b1;
    end else if (item_i.func == OP_DI) begin
      state_o.int_enable = 1'b0;
    end else if (item_i.func == OP_OUT) begin
      result_o.port_write    = 1'b1;
      result_o.port_number   = item_i.imm_word[7:0];
      result_o.port_data_out = item_i.acc;
    end else if (item_i.func == OP_IN) begin
      result_o.port_read   = 1'b1;
      result_o.port_number = item_i.imm_word[7:0];
      result_o.new_acc     = item_i.port_data_in;
    end

    if (do_call) begin
      result_o.next_sp    = item_i.stack_pointer - STACK_STEP;
      result_o.push_valid = 1'b1;
      result_o.next_pc    = target;
    end else if (do_ret) begin
      result_o.next_sp = item_i.stack_pointer + STACK_STEP;
      result_o.next_pc = item_i.stack_top_word;
    end

    result_o.halted_out      = state_o.halted;
    result_o.int_enabled_out = state_o.int_enable;
  end

endmodule

/* sv/cpu_branch_and_system_unit.sv */
// ----------------------------------------------------------------------------
// cpu_branch_and_system_unit: branch and system instruction unit
// Executes jump, call, return, restart, halt, interrupt enable and port
// instructions of an 8080-style processor, one per beat.
// ----------------------------------------------------------------------------
// The unit takes one instruction beat per clock cycle while the result side
// does not stall, and returns one result beat for each, in order. A beat is
// captured in the input register at acceptance, decoded by the execute logic
// and written to the result register once that register is empty or its beat
// leaves. The sustained rate is one beat per cycle while the receiver is
// ready, set by the single pass from input register to result register.
// Halt and interrupt enable are updated as a beat moves into the result
// register and are shown on every result; halt is sticky until reset. Both
// registers advance whenever the result side can take a beat. While a
// finished result waits, the input register takes one more beat and then
// holds, with in_ready_o low until the result leaves.
// ----------------------------------------------------------------------------
module cpu_branch_and_system_unit
  import cbsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  func_i,
  input  logic [15:0] imm_word_i,
  input  logic [15:0] fall_through_pc_i,
  input  logic [15:0] stack_pointer_i,
  input  logic [15:0] stack_top_word_i,
  input  logic [7:0]  acc_i,
  input  logic [7:0]  port_data_in_i,
  input  logic        zero_flag_i,
  input  logic        carry_flag_i,
  input  logic        parity_flag_i,
  input  logic        sign_flag_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [15:0] next_sp_o,
  output logic        push_valid_o,
  output logic [15:0] push_word_o,
  output logic        port_write_o,
  output logic        port_read_o,
  output logic [7:0]  port_number_o,
  output logic [7:0]  port_data_out_o,
  output logic [7:0]  new_acc_o,
  output logic [2:0]  extra_cycles_o,
  output logic        halted_out_o,
  output logic        int_enabled_out_o
);

  // Input register
  logic       in_vld_q;
  item_t      item_q;

  // Result register
  logic       out_vld_q;
  result_t    res_q;
  result_t    res_d;

  // Architectural state
  sys_state_t state_q;
  sys_state_t state_d;

  logic       out_load;
  logic       in_load;

  // Load the result register when it is empty or its beat leaves now
  assign out_load   = in_vld_q && (!out_vld_q || out_ready_i);
  // Take a new beat when the input register is empty or drains this cycle
  assign in_ready_o = !in_vld_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q.func            <= func_i;
      item_q.imm_word        <= imm_word_i;
      item_q.fall_through_pc <= fall_through_pc_i;
      item_q.stack_pointer   <= stack_pointer_i;
      item_q.stack_top_word  <= stack_top_word_i;
      item_q.acc             <= acc_i;
      item_q.port_data_in    <= port_data_in_i;
      item_q.zero_flag       <= zero_flag_i;
      item_q.carry_flag      <= carry_flag_i;
      item_q.parity_flag     <= parity_flag_i;
      item_q.sign_flag       <= sign_flag_i;
    end
  end

  cbsu_exec u_exec (
    .item_i   (item_q),
    .state_i  (state_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  // Commit state only as the beat moves on, keeping program order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (out_load) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign next_pc_o         = res_q.next_pc;
  assign next_sp_o         = res_q.next_sp;
  assign push_valid_o      = res_q.push_valid;
  assign push_word_o       = res_q.push_word;
  assign port_write_o      = res_q.port_write;
  assign port_read_o       = res_q.port_read;
  assign port_number_o     = res_q.port_number;
  assign port_data_out_o   = res_q.port_data_out;
  assign new_acc_o         = res_q.new_acc;
  assign extra_cycles_o    = res_q.extra_cycles;
  assign halted_out_o      = res_q.halted_out;
  assign int_enabled_out_o = res_q.int_enabled_out;

`ifndef SYNTHESIS
  // Halt is sticky: once set it stays until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |=> state_q.halted)
    else $error("halt state cleared without reset");

  // Extra cycles only ever take the taken-conditional value
  a_extra_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (extra_cycles_o != 3'd0) |-> extra_cycles_o == TAKEN_EXTRA)
    else $error("unexpected extra cycle count");

  // A port beat is never both a read and a write
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(port_write_o && port_read_o))
    else $error("port read and write in one beat");

  // An empty input register must always accept
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input stalled while input register empty");

  // Shown state matches the committed state
  a_state_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (halted_out_o == state_q.halted)
                 && (int_enabled_out_o == state_q.int_enable))
    else $error("result state differs from committed state");
`endif

endmodule

/* verif/cpu_branch_and_system_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_branch_and_system_unit_tb: self-checking bench for the branch unit
// Drives a directed table of control and system instructions, then about two
// thousand random ones, through the valid/ready input with bursty pacing and
// a stalling receiver. Each result beat is checked field by field against a
// table row or an in-bench executor that tracks halt and interrupt enable.
// ----------------------------------------------------------------------------
module cpu_branch_and_system_unit_tb;
  import cbsu_pkg::*;

  localparam int unsigned N_RANDOM   = 2000;
  localparam int unsigned N_PLAN     = 25;
  localparam int unsigned IDLE_LIMIT = 1000;  // cycles without any beat
  localparam int unsigned DRAIN_WAIT = 8;     // edges to wait after the drain
  localparam int unsigned MAX_REPORT = 10;

  logic    clk_i = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    out_ready = 1'b0;
  item_t   stim = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] next_pc_o;
  logic [15:0] next_sp_o;
  logic        push_valid_o;
  logic [15:0] push_word_o;
  logic        port_write_o;
  logic        port_read_o;
  logic [7:0]  port_number_o;
  logic [7:0]  port_data_out_o;
  logic [7:0]  new_acc_o;
  logic [2:0]  extra_cycles_o;
  logic        halted_out_o;
  logic        int_enabled_out_o;

  // Executor state: mirrors the halt and interrupt-enable flops
  logic        cpu_halted = 1'b0;
  logic        irq_enabled = 1'b0;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  cpu_branch_and_system_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .func_i            (stim.func),
    .imm_word_i        (stim.imm_word),
    .fall_through_pc_i (stim.fall_through_pc),
    .stack_pointer_i   (stim.stack_pointer),
    .stack_top_word_i  (stim.stack_top_word),
    .acc_i             (stim.acc),
    .port_data_in_i    (stim.port_data_in),
    .zero_flag_i       (stim.zero_flag),
    .carry_flag_i      (stim.carry_flag),
    .parity_flag_i     (stim.parity_flag),
    .sign_flag_i       (stim.sign_flag),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .next_pc_o         (next_pc_o),
    .next_sp_o         (next_sp_o),
    .push_valid_o      (push_valid_o),
    .push_word_o       (push_word_o),
    .port_write_o      (port_write_o),
    .port_read_o       (port_read_o),
    .port_number_o     (port_number_o),
    .port_data_out_o   (port_data_out_o),
    .new_acc_o         (new_acc_o),
    .extra_cycles_o    (extra_cycles_o),
    .halted_out_o      (halted_out_o),
    .int_enabled_out_o (int_enabled_out_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Executor
  // --------------------------------------------------------------------------

  // Bits 5:4 pick the flag, bit 3 says whether the flag must be set or clear.
  function automatic logic cond_holds(logic [7:0] op, item_t it);
    flag_sel_e sel;
    logic      f;
    sel = flag_sel_e'(op[5:4]);
    case (sel)
      FLAG_ZERO:   f = it.zero_flag;
      FLAG_CARRY:  f = it.carry_flag;
      FLAG_PARITY: f = it.parity_flag;
      default:     f = it.sign_flag;
    endcase
    return op[3] ? f : !f;
  endfunction

  // Execute one instruction and advance the halt and interrupt-enable state.
  function automatic result_t exec_control(item_t it);
    result_t     r;
    logic [7:0]  op;
    logic        take;
    logic        do_call;
    logic        do_ret;
    logic [15:0] dest;
    op      = it.func;
    take    = cond_holds(op, it);
    do_call = 1'b0;
    do_ret  = 1'b0;
    dest    = it.imm_word;
    r           = '0;
    r.next_pc   = it.fall_through_pc;
    r.next_sp   = it.stack_pointer;
    r.push_word = it.fall_through_pc;
    r.new_acc   = it.acc;
    // Order of the decode chain: each unconditional form is tested before its conditional one.
    if (op == OP_JMP || op == OP_JMP_ALT) begin
      r.next_pc = it.imm_word;
    end else if ((op & MASK_CCC) == PAT_JCC) begin
      if (take) r.next_pc = it.imm_word;
    end else if ((op & MASK_CALL) == PAT_CALL) begin
      do_call = 1'b1;
    end else if ((op & MASK_CCC) == PAT_CCC) begin
      if (take) begin
        do_call        = 1'b1;
        r.extra_cycles = TAKEN_EXTRA;
      end
    end else if (op == OP_RET || op == OP_RET_ALT) begin
      do_ret = 1'b1;
    end else if ((op & MASK_CCC) == PAT_RCC) begin
      if (take) begin
        do_ret         = 1'b1;
        r.extra_cycles = TAKEN_EXTRA;
      end
    end else if ((op & MASK_CCC) == PAT_RST) begin
      do_call = 1'b1;
      dest    = {8'h00, op & RST_MASK};
    end else if (op == OP_HLT) begin
      cpu_halted = 1'b1;
    end else if (op == OP_EI) begin
      irq_enabled = 1'b1;
    end else if (op == OP_DI) begin
      irq_enabled = 1'b0;
    end else if (op == OP_OUT) begin
      r.port_write    = 1'b1;
      r.port_number   = it.imm_word[7:0];
      r.port_data_out = it.acc;
    end else if (op == OP_IN) begin
      r.port_read   = 1'b1;
      r.port_number = it.imm_word[7:0];
      r.new_acc     = it.port_data_in;
    end
    if (do_call) begin
      r.next_sp    = it.stack_pointer - STACK_STEP;
      r.push_valid = 1'b1;
      r.next_pc    = dest;
    end else if (do_ret) begin
      r.next_sp = it.stack_pointer + STACK_STEP;
      r.next_pc = it.stack_top_word;
    end
    r.halted_out      = cpu_halted;
    r.int_enabled_out = irq_enabled;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic item_t mk_item(logic [7:0] op, logic [15:0] imm, logic [15:0] ftpc,
                                    logic [15:0] sp, logic [15:0] top, logic [7:0] acc,
                                    logic [7:0] pin, logic [3:0] zcps);
    item_t it;
    it.func            = op;
    it.imm_word        = imm;
    it.fall_through_pc = ftpc;
    it.stack_pointer   = sp;
    it.stack_top_word  = top;
    it.acc             = acc;
    it.port_data_in    = pin;
    {it.zero_flag, it.carry_flag, it.parity_flag, it.sign_flag} = zcps;
    return it;
  endfunction

  // Result with no port action, no extra cycles, halt and interrupts clear.
  function automatic result_t quiet_result(logic [15:0] pc, logic [15:0] sp, logic pv,
                                           logic [15:0] pw, logic [7:0] acc);
    result_t r;
    r            = '0;
    r.next_pc    = pc;
    r.next_sp    = sp;
    r.push_valid = pv;
    r.push_word  = pw;
    r.new_acc    = acc;
    return r;
  endfunction

  // Weight the mix towards control flow; three in sixteen opcodes are raw bytes.
  function automatic item_t rand_item();
    item_t      it;
    logic [2:0] ccc;
    int unsigned pick;
    ccc  = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 15);
    it.imm_word        = 16'($urandom);
    it.fall_through_pc = 16'($urandom);
    it.stack_top_word  = 16'($urandom);
    it.acc             = 8'($urandom);
    it.port_data_in    = 8'($urandom);
    {it.zero_flag, it.carry_flag, it.parity_flag, it.sign_flag} = 4'($urandom);
    // Lean on the ends of the stack range so push and pop wrap often.
    case ($urandom_range(0, 7))
      0:       it.stack_pointer = 16'($urandom_range(0, 3));
      1:       it.stack_pointer = 16'hFFFF - 16'($urandom_range(0, 3));
      default: it.stack_pointer = 16'($urandom);
    endcase
    case (pick)
      0, 1, 2: it.func = PAT_JCC | {2'b00, ccc, 3'b000};
      3, 4, 5: it.func = PAT_CCC | {2'b00, ccc, 3'b000};
      6, 7, 8: it.func = PAT_RCC | {2'b00, ccc, 3'b000};
      9:       it.func = PAT_RST | {2'b00, ccc, 3'b000};
      10: begin
        case ($urandom_range(0, 4))
          0:       it.func = OP_JMP;
          1:       it.func = OP_JMP_ALT;
          2:       it.func = OP_RET;
          3:       it.func = OP_RET_ALT;
          default: it.func = PAT_CALL | {2'($urandom_range(0, 3)), 6'h00} >> 2;
        endcase
      end
      11:      it.func = ccc[0] ? OP_IN : OP_OUT;
      12:      it.func = ccc[0] ? OP_EI : OP_DI;
      default: it.func = 8'($urandom);
    endcase
    return it;
  endfunction

  // Offer one beat and hold it until the unit takes it. Called at a rising
  // edge; returns at the edge of acceptance.
  task automatic offer_beat(input item_t it, input bit typed, input result_t typed_res);
    result_t pred;
    in_valid <= 1'b1;
    stim     <= it;
    do @(posedge clk_i); while (!in_ready_o);
    // Run the executor even for typed rows so its state keeps step.
    pred = exec_control(it);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Close a burst with a random gap, or carry straight on.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random items, drain, verdict
  // --------------------------------------------------------------------------
  initial begin : main_seq
    item_t       plan_item [N_PLAN];
    bit          plan_typed[N_PLAN];
    result_t     plan_res  [N_PLAN];
    int unsigned n;

    plan_typed = '{default: 1'b0};
    plan_res   = '{default: '0};

    // Do-nothing opcode with every field at zero, then at its top value.
    plan_item[0]  = mk_item(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'h0);
    plan_typed[0] = 1'b1;
    plan_res[0]   = quiet_result(16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00);
    plan_item[1]  = mk_item(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 4'hF);
    plan_typed[1] = 1'b1;
    plan_res[1]   = quiet_result(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 8'hFF);
    // Plain jumps
    plan_item[2]  = mk_item(OP_JMP, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 8'h11, 8'h22, 4'h0);
    plan_typed[2] = 1'b1;
    plan_res[2]   = quiet_result(16'hFFFF, 16'h8000, 1'b0, 16'h0001, 8'h11);
    plan_item[3]  = mk_item(OP_JMP_ALT, 16'h0000, 16'hFFFF, 16'h1234, 16'h4321, 8'h80, 8'h01, 4'hA);
    // Conditional jumps: NZ with zero set falls through, Z taken, C not met,
    // PE and M taken
    plan_item[4]  = mk_item(8'hC2, 16'hBEEF, 16'h0100, 16'h2000, 16'h0000, 8'h00, 8'h00, 4'h8);
    plan_item[5]  = mk_item(8'hCA, 16'hBEEF, 16'h0100, 16'h2000, 16'h0000, 8'h00, 8'h00, 4'h8);
    plan_item[6]  = mk_item(8'hDA, 16'h1111, 16'h0200, 16'h2000, 16'h0000, 8'h00, 8'h00, 4'hB);
    plan_item[7]  = mk_item(8'hEA, 16'h2222, 16'h0300, 16'h2000, 16'h0000, 8'h00, 8'h00, 4'h2);
    plan_item[8]  = mk_item(8'hFA, 16'h3333, 16'h0400, 16'h2000, 16'h0000, 8'h00, 8'h00, 4'h1);
    // Plain call at the bottom of the stack: SP wraps to the top
    plan_item[9]  = mk_item(PAT_CALL, 16'h1234, 16'hABCD, 16'h0000, 16'h0000, 8'h5A, 8'h00, 4'h0);
    plan_typed[9] = 1'b1;
    plan_res[9]   = quiet_result(16'h1234, 16'hFFFE, 1'b1, 16'hABCD, 8'h5A);
    plan_item[10] = mk_item(8'hFD, 16'h0F0F, 16'h00FF, 16'h0001, 16'h0000, 8'h00, 8'h00, 4'hF);
    // Conditional calls: NZ taken, M not met
    plan_item[11] = mk_item(8'hC4, 16'h4000, 16'h0010, 16'h1000, 16'h0000, 8'h00, 8'h00, 4'h0);
    plan_item[12] = mk_item(8'hFC, 16'h4000, 16'h0010, 16'h1000, 16'h0000, 8'h00, 8'h00, 4'hE);
    // Plain return at the top of the stack: SP wraps to the bottom
    plan_item[13] = mk_item(OP_RET, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 8'h3C, 8'h00, 4'h0);
    plan_typed[13] = 1'b1;
    plan_res[13]  = quiet_result(16'h5555, 16'h0001, 1'b0, 16'h0001, 8'h3C);
    plan_item[14] = mk_item(OP_RET_ALT, 16'h0000, 16'h0002, 16'hFFFE, 16'hAAAA, 8'h00, 8'h00, 4'h5);
    // Conditional returns: PE taken, PO not met
    plan_item[15] = mk_item(8'hE8, 16'h0000, 16'h0030, 16'h3000, 16'h7777, 8'h00, 8'h00, 4'h2);
    plan_item[16] = mk_item(8'hE0, 16'h0000, 16'h0030, 16'h3000, 16'h7777, 8'h00, 8'h00, 4'h2);
    // Restarts to the lowest and highest vector
    plan_item[17] = mk_item(PAT_RST, 16'hFFFF, 16'h1001, 16'h0100, 16'h0000, 8'h00, 8'h00, 4'h0);
    plan_item[18] = mk_item(8'hFF, 16'hFFFF, 16'h1002, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'hF);
    // Interrupt enable, disable, enable again
    plan_item[19] = mk_item(OP_EI, 16'h0000, 16'h0050, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'h0);
    plan_item[20] = mk_item(OP_DI, 16'h0000, 16'h0051, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'h0);
    plan_item[21] = mk_item(OP_EI, 16'h0000, 16'h0052, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'h0);
    // Port write, port read
    plan_item[22] = mk_item(OP_OUT, 16'hABFF, 16'h0060, 16'h0000, 16'h0000, 8'h5A, 8'hA5, 4'h0);
    plan_item[23] = mk_item(OP_IN, 16'h12A5, 16'h0061, 16'h0000, 16'h0000, 8'h5A, 8'hC3, 4'h0);
    // Halt; it stays set for the rest of the run, random items included
    plan_item[24] = mk_item(OP_HLT, 16'h0000, 16'h0070, 16'h0000, 16'h0000, 8'h00, 8'h00, 4'h0);

    // Hold reset, then release on an edge.
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < N_PLAN; n++) begin
      offer_beat(plan_item[n], plan_typed[n], plan_res[n]);
      pace_sender();
    end
    for (n = 0; n < N_RANDOM; n++) begin
      offer_beat(rand_item(), 1'b0, '0);
      pace_sender();
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then a few more edges to
    // catch any stray beat.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d result beats never arrived", pending_results.size());
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: a periodically redrawn stall pattern, plus two long hold-offs
  // while the sender keeps offering so the unit backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold;
    int unsigned mode;
    logic [15:0] mask;
    cyc  = 0;
    hold = 0;
    mode = 0;
    mask = 16'hFFFF;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 2);
        mask = 16'($urandom);
      end
      if (cyc == 400 || cyc == 2500) hold = 80;
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) > 2);
          default: out_ready <= mask[cyc[3:0]];
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORT) $display("%t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) note_error($sformatf("%s: expected %h, got %h", name, want, got));
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("result beat with nothing outstanding, next_pc %h", next_pc_o));
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc",         want.next_pc,              next_pc_o);
        check_field("next_sp",         want.next_sp,              next_sp_o);
        check_field("push_valid",      16'(want.push_valid),      16'(push_valid_o));
        check_field("push_word",       want.push_word,            push_word_o);
        check_field("port_write",      16'(want.port_write),      16'(port_write_o));
        check_field("port_read",       16'(want.port_read),       16'(port_read_o));
        check_field("port_number",     16'(want.port_number),     16'(port_number_o));
        check_field("port_data_out",   16'(want.port_data_out),   16'(port_data_out_o));
        check_field("new_acc",         16'(want.new_acc),         16'(new_acc_o));
        check_field("extra_cycles",    16'(want.extra_cycles),    16'(extra_cycles_o));
        check_field("halted_out",      16'(want.halted_out),      16'(halted_out_o));
        check_field("int_enabled_out", 16'(want.int_enabled_out), 16'(int_enabled_out_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: drop the run if no beat moves on either side for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    int unsigned idle;
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", idle);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
